[sv/tehc_pkg.sv]
package tehc_pkg;

  localparam logic [1:0] FMT_HALF   = 2'd0;
  localparam logic [1:0] FMT_SINGLE = 2'd1;
  localparam logic [1:0] FMT_BF16   = 2'd2;
  localparam logic [1:0] FMT_Q8     = 2'd3;

  // Operation picked by the front end for the back end.
  typedef enum logic [1:0] {
    OP_PASS   = 2'd0,
    OP_NARROW = 2'd1,
    OP_QMUL   = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] bits;   // float bits to narrow, or half bits to pass
    logic [31:0] scale;  // scale for a quant multiply
    logic [7:0]  quant;
    logic        last;
  } work_t;

  // Single-precision bits to half bits, rounding on bit 12 with ties away from zero.
  function automatic logic [15:0] narrow(input logic [31:0] f);
    logic [15:0] sign;
    logic [22:0] mant;
    logic [7:0]  efld;
    logic signed [9:0] e;
    logic [23:0] sm;
    logic [4:0]  sh;
    logic [23:0] rm;
    logic [15:0] res;
    sign = {f[31], 15'd0};
    mant = f[22:0];
    efld = f[30:23];
    e    = $signed({2'b00, efld}) - 10'sd112;
    if (efld == 8'hff) begin
      res = sign | 16'h7c00 | ((mant != 23'd0) ? 16'h0200 : 16'h0000);
    end else if (e >= 10'sd31) begin
      res = sign | 16'h7c00;
    end else if (e <= 10'sd0) begin
      if (e < -10'sd10) begin
        res = sign;
      end else begin
        sh = 5'(10'sd1 - e);
        sm = {1'b1, mant} >> sh;
        if (sm[12]) sm = sm + 24'h2000;
        // A carry into bit 23 turns the subnormal into the smallest normal.
        res = sign | {5'd0, sm[23:13]};
      end
    end else begin
      rm = {1'b0, mant};
      if (mant[12]) begin
        rm = rm + 24'h2000;
        if (rm[23]) begin
          rm = 24'd0;
          e = e + 10'sd1;
        end
      end
      if (e >= 10'sd31) res = sign | 16'h7c00;
      else res = sign | {1'b0, e[4:0], rm[22:13]};
    end
    return res;
  endfunction

  // Half bits to single bits; subnormals normalized by a leading-zero count.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  lz;
    logic [10:0] nm;
    logic [31:0] res;
    e = h[14:10];
    m = h[9:0];
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) lz = 4'(9 - i);
    end
    nm = {1'b0, m} << (lz + 4'd1);
    if (e == 5'd0) begin
      if (m == 10'd0) res = {h[15], 31'd0};
      else res = {h[15], 8'(8'd113 - 8'(lz) - 8'd1), nm[9:0], 13'd0};
    end else if (e == 5'd31) begin
      res = {h[15], 8'hff, m, 13'd0};
    end else begin
      res = {h[15], 8'(8'(e) + 8'd112), m, 13'd0};
    end
    return res;
  endfunction

endpackage

[sv/tehc_front.sv]
module tehc_front
  import tehc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  source_format,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  input  logic        in_is_scale,
  input  logic        in_last_in,
  output logic        q_valid,
  output work_t       q_data,
  input  logic        q_full
);

  logic [31:0] block_scale_r;
  logic        accept;
  logic        scale_item;

  assign in_stall   = q_full;
  assign accept     = in_valid && !q_full;
  assign scale_item = (source_format == FMT_Q8) && in_is_scale;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_scale_r <= 32'd0;
    end else if (accept && scale_item) begin
      block_scale_r <= widen_half(in_value[15:0]);
    end
  end

  always_comb begin
    q_valid = accept && !scale_item;
    q_data.bits  = in_value;
    q_data.scale = block_scale_r;
    q_data.quant = in_value[7:0];
    q_data.last  = in_last_in;
    case (source_format)
      FMT_HALF: begin
        q_data.op   = OP_PASS;
        q_data.bits = {16'd0, in_value[15:0]};
      end
      FMT_SINGLE: q_data.op = OP_NARROW;
      FMT_BF16: begin
        q_data.op   = OP_NARROW;
        q_data.bits = {in_value[15:0], 16'd0};
      end
      default: q_data.op = OP_QMUL;
    endcase
  end

endmodule

[sv/tehc_queue.sv]
module tehc_queue
  import tehc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  input  work_t wr_data,
  output logic  full,
  output logic  rd_valid,
  output work_t rd_data,
  input  logic  rd_ready
);

  work_t       mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        do_rd;

  assign full     = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_valid) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid) wp_r <= !wp_r;
      if (do_rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr_valid) - 2'(do_rd);
    end
  end

endmodule

[sv/tehc_back.sv]
module tehc_back
  import tehc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        w_valid,
  input  work_t       w_data,
  output logic        w_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_half_value,
  output logic        out_last
);

  // Stage 1: quant magnitude times scale mantissa, or bits for narrowing.
  logic        s1_valid_r;
  op_t         s1_op_r;
  logic [31:0] s1_bits_r;
  logic [31:0] s1_scale_r;
  logic        s1_neg_r;
  logic [7:0]  s1_mag_r;
  logic [31:0] s1_prod_r;
  logic        s1_last_r;

  logic        s1_adv, out_adv;
  logic [7:0]  mag;
  logic [7:0]  e;
  logic [22:0] m;
  logic [31:0] psign, prod_f;
  logic [3:0]  sh;
  logic [8:0]  esum;
  logic [31:0] ps;
  logic [15:0] res;

  assign out_adv = !out_valid || !out_stall;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign w_ready = s1_adv;
  assign mag     = w_data.quant[7] ? 8'(9'd256 - {1'b0, w_data.quant}) : w_data.quant;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= w_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && w_valid) begin
      s1_op_r    <= w_data.op;
      s1_bits_r  <= w_data.bits;
      s1_scale_r <= w_data.scale;
      s1_neg_r   <= w_data.quant[7];
      s1_mag_r   <= mag;
      s1_prod_r  <= 32'(mag) * {8'd0, 1'b1, w_data.scale[22:0]};
      s1_last_r  <= w_data.last;
    end
  end

  // Stage 2: normalize the product, then narrow it or the stage-1 bits; half bits pass through.
  always_comb begin
    e     = s1_scale_r[30:23];
    m     = s1_scale_r[22:0];
    psign = {s1_scale_r[31] ^ s1_neg_r, 31'd0};
    sh    = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (s1_prod_r[24 + i]) sh = 4'(i + 1);
    end
    esum = {1'b0, e} + 9'(sh);
    ps   = s1_prod_r >> sh;
    if (e == 8'hff) begin
      if (m != 23'd0) prod_f = {s1_scale_r[31], 8'hff, 1'b1, m[21:0]} | {9'd0, m};
      else if (s1_mag_r == 8'd0) prod_f = 32'h7fc00000;
      else prod_f = psign | 32'h7f800000;
    end else if (e == 8'd0 || s1_mag_r == 8'd0) begin
      prod_f = psign;
    end else if (esum >= 9'd255) begin
      prod_f = psign | 32'h7f800000;
    end else begin
      prod_f = psign | {1'b0, esum[7:0], ps[22:0]};
    end
    case (s1_op_r)
      OP_PASS:   res = s1_bits_r[15:0];
      OP_NARROW: res = narrow(s1_bits_r);
      default:   res = narrow(prod_f);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_half_value <= res;
      out_last       <= s1_last_r;
    end
  end

endmodule

[sv/tensor_element_to_half_converter_top.sv]
// Converts a stream of weight elements to IEEE half values.
// Input channel: in_valid/in_stall with in_value, in_is_scale, in_last_in.
// Result channel: out_valid/out_stall with out_half_value and out_last.
// cfg_* is an APB-style port; register 0 at address 0 is source_format
// (0 half, 1 single, 2 bfloat16, 3 q8_0). Write it only while idle.
// In q8_0 mode a beat with in_is_scale set loads the block scale and
// produces no result; quants that follow are scaled by it.
// One beat is accepted per cycle while in_stall is low. An accepted beat
// is written into the two-entry queue, then loaded into the 8x24 multiply
// stage, and then its normalize-and-narrow result is loaded into the
// output register.
// When out_stall holds, the output and multiply stages hold, the queue
// fills, and in_stall rises once it has two entries waiting.
// Reset clears the format to half, the scale to +0.0 and all valid bits.
module tensor_element_to_half_converter_top
  import tehc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  input  logic        in_is_scale,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_half_value,
  output logic        out_last
);

  logic [1:0] source_format_r;
  logic       q_valid, q_full, w_valid, w_ready;
  work_t      q_data, w_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {30'd0, source_format_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_format_r <= FMT_HALF;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      source_format_r <= cfg_pwdata[1:0];
    end
  end

  tehc_front u_front (
    .clk, .rst_n, .source_format(source_format_r),
    .in_valid, .in_stall, .in_value, .in_is_scale, .in_last_in,
    .q_valid, .q_data, .q_full
  );

  tehc_queue u_queue (
    .clk, .rst_n, .wr_valid(q_valid), .wr_data(q_data), .full(q_full),
    .rd_valid(w_valid), .rd_data(w_data), .rd_ready(w_ready)
  );

  tehc_back u_back (
    .clk, .rst_n, .w_valid, .w_data, .w_ready,
    .out_valid, .out_stall, .out_half_value, .out_last
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_half_value))
    else $error("result changed under stall");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_valid)
    else $error("queue written while full");
  a_q8_scale_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_is_scale && source_format_r == FMT_Q8 |-> !q_valid)
    else $error("scale beat produced work");

endmodule

[dv/tensor_element_to_half_converter_top_test.sv]
module tensor_element_to_half_converter_top_test
  import tehc_pkg::*;
();

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_value;
  logic        in_is_scale;
  logic        in_last_in;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_half_value;
  logic        out_last;

  localparam logic [1:0] ADDR_SOURCE_FORMAT = 2'd0;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] half_value;
    logic        last;
  } half_beat_t;

  half_beat_t  expected_halves[$];
  logic [1:0]  model_format;
  logic [31:0] model_scale;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          error_count;
  longint      cycle_count;

  tensor_element_to_half_converter_top u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Single bits to half bits; ties on bit 12 go away from zero.
  function automatic logic [15:0] to_half(input logic [31:0] f);
    logic [15:0] sgn;
    logic [23:0] frac;
    int          ex;
    sgn  = {f[31], 15'd0};
    frac = {1'b0, f[22:0]};
    ex   = int'(f[30:23]) - 112;
    if (f[30:23] == 8'hff) return sgn | 16'h7c00 | (f[22:0] != 0 ? 16'h0200 : 16'h0);
    if (ex >= 31) return sgn | 16'h7c00;
    if (ex <= 0) begin
      if (ex < -10) return sgn;
      frac = {1'b1, f[22:0]} >> (1 - ex);
      if (frac[12]) frac = frac + 24'h2000;
      return sgn | 16'(frac >> 13);
    end
    if (frac[12]) begin
      frac = frac + 24'h2000;
      if (frac[23]) begin
        frac = 24'd0;
        ex++;
      end
      if (ex >= 31) return sgn | 16'h7c00;
    end
    return sgn | 16'(ex << 10) | 16'(frac[22:13]);
  endfunction

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] sgn;
    logic [10:0] m;
    int          ex;
    sgn = {h[15], 31'd0};
    ex  = int'(h[14:10]);
    m   = {1'b0, h[9:0]};
    if (ex == 0) begin
      if (m == 0) return sgn;
      ex = 1;
      while (!m[10]) begin
        m = m << 1;
        ex--;
      end
      return sgn | (32'(ex + 112) << 23) | (32'(m[9:0]) << 13);
    end
    if (ex == 31) return sgn | 32'h7f800000 | (32'(m[9:0]) << 13);
    return sgn | (32'(ex + 112) << 23) | (32'(m[9:0]) << 13);
  endfunction

  function automatic logic [31:0] scaled_quant(input logic [31:0] s, input logic [7:0] q);
    logic [7:0]  mag;
    logic [31:0] psgn;
    logic [31:0] prod;
    int          sh;
    mag  = q[7] ? 8'(-q) : q;
    psgn = {s[31] ^ q[7], 31'd0};
    if (s[30:23] == 8'hff) begin
      if (s[22:0] != 0) return {s[31], 31'h7fc00000} | {9'd0, s[22:0]};
      if (mag == 0 && !q[7]) return 32'h7fc00000;
      return psgn | 32'h7f800000;
    end
    if (s[30:23] == 0 || (mag == 0 && !q[7])) return psgn;
    // -128 has magnitude 128, which the 8-bit negate keeps as 0x80.
    prod = 32'(mag) * {8'd0, 1'b1, s[22:0]};
    sh = 0;
    while (sh < 8 && (prod >> (24 + sh)) != 0) sh++;
    if (int'(s[30:23]) + sh >= 255) return psgn | 32'h7f800000;
    return psgn | (32'(int'(s[30:23]) + sh) << 23) | ((prod >> sh) & 32'h007fffff);
  endfunction

  function automatic void predict_element(input logic [31:0] v, input logic sc,
                                          input logic lst);
    logic [15:0] h;
    half_beat_t  beat;
    case (model_format)
      FMT_HALF:   h = v[15:0];
      FMT_SINGLE: h = to_half(v);
      FMT_BF16:   h = to_half({v[15:0], 16'd0});
      default: begin
        if (sc) begin
          model_scale = half_to_single(v[15:0]);
          return;
        end
        h = to_half(scaled_quant(model_scale, v[7:0]));
      end
    endcase
    beat.half_value = h;
    beat.last       = lst;
    expected_halves.insert(expected_halves.size(), beat);
  endfunction

  // Receiver: random stall, check every accepted beat.
  always @(posedge clk) begin
    half_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_halves.size() == 0) begin
        $display("%0t: unexpected result half=%h last=%b", $time, out_half_value, out_last);
        error_count++;
      end else begin
        want = expected_halves.pop_front();
        if (out_half_value !== want.half_value) begin
          $display("%0t: half_value expected %h actual %h", $time, want.half_value,
                   out_half_value);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, out_last);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Leaves in_valid high after the accepting edge; the next caller drives it.
  task automatic send_element(input logic [31:0] v, input logic sc, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_value    <= v;
    in_is_scale <= sc;
    in_last_in  <= lst;
    do @(posedge clk); while (in_stall);
    predict_element(v, sc, lst);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_halves.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_format(input logic [1:0] fmt);
    drain();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_SOURCE_FORMAT;
    cfg_pwdata  <= 32'(fmt);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    model_format = fmt;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] random_single();
    case ($urandom_range(5))
      0: return {1'($urandom_range(1)), 8'($urandom_range(102, 114)), 23'($urandom)};
      1: return {1'($urandom_range(1)), 8'($urandom_range(140, 144)), 23'($urandom)};
      2: return {1'($urandom_range(1)), 8'hff, 23'($urandom_range(1))};
      3: return {1'($urandom_range(1)), 8'($urandom_range(113, 142)), 10'($urandom),
                 13'h1000};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_half_passthrough;
    write_format(FMT_HALF);
    send_element(32'h0000_0000, 1'b0, 1'b0);
    send_element(32'hffff_ffff, 1'b1, 1'b1);
    send_element(32'h1234_7c00, 1'b0, 1'b0);
  endtask

  task automatic test_single_narrow;
    write_format(FMT_SINGLE);
    send_element(32'h7f80_0000, 1'b0, 1'b0);
    send_element(32'hff80_0001, 1'b0, 1'b1);
    send_element(32'h477f_f000, 1'b0, 1'b0);  // rounds up into infinity
    send_element(32'h3f80_1000, 1'b0, 1'b0);  // tie on bit 12
    send_element(32'h3380_0000, 1'b0, 1'b0);  // smallest subnormal
    send_element(32'hb300_0000, 1'b0, 1'b0);  // tie rounds to the negative smallest subnormal
    send_element(32'h387f_f000, 1'b0, 1'b1);  // subnormal rounding to normal
  endtask

  task automatic test_bf16_widen;
    write_format(FMT_BF16);
    send_element(32'hffff_7fc1, 1'b1, 1'b0);
    send_element(32'h0000_0001, 1'b0, 1'b1);
    send_element(32'h0000_c780, 1'b0, 1'b0);
  endtask

  task automatic test_q8_blocks;
    write_format(FMT_Q8);
    send_element(32'h0000_0005, 1'b0, 1'b0);  // quant before any scale
    send_element(32'h0000_8000, 1'b1, 1'b1);  // negative zero scale
    send_element(32'h0000_0000, 1'b0, 1'b0);
    send_element(32'h0000_0001, 1'b1, 1'b0);  // subnormal scale
    send_element(32'h0000_0080, 1'b0, 1'b1);
    send_element(32'h0000_7bff, 1'b1, 1'b0);  // largest half overflows
    send_element(32'h0000_007f, 1'b0, 1'b0);
    send_element(32'h0000_7c00, 1'b1, 1'b0);  // infinite scale
    send_element(32'h0000_0000, 1'b0, 1'b0);
    send_element(32'h0000_00ff, 1'b0, 1'b0);
    send_element(32'h0000_fd00, 1'b1, 1'b0);  // NaN scale
    send_element(32'hffff_ff03, 1'b0, 1'b1);
  endtask

  task automatic test_random_stream(input int count);
    int       left;
    int       blk;
    logic [1:0] fmt;
    left = count;
    while (left > 0) begin
      fmt = 2'($urandom_range(3));
      write_format(fmt);
      for (int k = 0; k < 40 && left > 0; k++) begin
        if (fmt == FMT_Q8 && $urandom_range(9) != 0) begin
          send_element($urandom_range(3) == 0 ? $urandom :
                       {16'($urandom), 1'b0, 5'($urandom_range(1, 30)), 10'($urandom)},
                       1'b1, 1'($urandom_range(1)));
          blk = $urandom_range(1, 8);
          repeat (blk) send_element($urandom, 1'b0, 1'($urandom_range(1)));
          left -= blk + 1;
        end else begin
          send_element(fmt == FMT_SINGLE ? random_single() : $urandom,
                       1'($urandom_range(1)), 1'($urandom_range(1)));
          left--;
        end
      end
    end
  endtask

  task automatic test_idle_phases;
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random_stream(330);
    send_idle_pct = 67; recv_stall_pct = 0;  test_random_stream(330);
    // Let the pipeline empty completely before resuming.
    drain();
    send_idle_pct = 0;  recv_stall_pct = 67; test_random_stream(330);
    send_idle_pct = 18; recv_stall_pct = 18; test_random_stream(330);
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = ADDR_SOURCE_FORMAT;
    cfg_pwdata = 32'd0;
    in_valid = 1'b0;
    in_value = 32'd0;
    in_is_scale = 1'b0;
    in_last_in = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    model_format = FMT_HALF;
    model_scale = 32'd0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_half_passthrough();
    test_single_narrow();
    test_bf16_widen();
    test_q8_blocks();
    test_idle_phases();
    drain();
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
sv/tehc_pkg.sv
sv/tehc_front.sv
sv/tehc_queue.sv
sv/tehc_back.sv
sv/tensor_element_to_half_converter_top.sv
dv/tensor_element_to_half_converter_top_test.sv
